/* hw/rtl/hrgo_pkg.sv */
// shared types, constants and the arctangent table for the heading offset block
`default_nettype none
package hrgo_pkg;

   // number of rotation cells, capped at the length of the arctangent table
   localparam int CORDIC_STAGES = 16;
   localparam int TABLE_LEN     = 24;
   localparam int NUM_CELLS     = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
   localparam int STAGE_W       = $clog2(TABLE_LEN);

   // datapath widths
   localparam int POS_W   = 40;
   localparam int ALT_W   = 24;
   localparam int OFS_W   = 24;
   localparam int HDG_W   = 16;
   localparam int XY_W    = 34;
   localparam int Z_W     = 34;
   localparam int Q_BITS  = 30;
   localparam int PROD_W  = OFS_W + XY_W;
   localparam int DIFF_W  = PROD_W + 2;
   localparam int DELTA_W = DIFF_W - Q_BITS;

   // stream payload widths, packed to whole bytes
   localparam int REQ_W = 2 * POS_W + 2 * ALT_W + HDG_W + 3 * OFS_W;
   localparam int RSP_W = 2 * POS_W + 2 * ALT_W + HDG_W;

   // registers from input to output
   localparam int PIPE_DEPTH = NUM_CELLS + 4;
   localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

   // inverse cordic gain, q4.30
   localparam logic signed [XY_W-1:0] CORDIC_X0 = XY_W'(652032874);

   // angle limits in 2^-32 turn
   localparam logic signed [Z_W-1:0] QUARTER_TURN = Z_W'(64'sd1073741824);
   localparam logic signed [Z_W-1:0] HALF_TURN    = Z_W'(64'sd2147483648);

   // one half in the q30 products
   localparam logic signed [DIFF_W-1:0] ROUND_HALF = DIFF_W'(64'sd536870912);

   // values passed alongside the rotation
   typedef struct packed {
      logic signed [POS_W-1:0] north;
      logic signed [POS_W-1:0] east;
      logic signed [OFS_W-1:0] fwd;
      logic signed [OFS_W-1:0] right;
      logic signed [ALT_W-1:0] alt_rel;
      logic signed [ALT_W-1:0] alt_abs;
      logic        [HDG_W-1:0] heading;
      logic                    flip;
   } pass_type;

   // rotation state held in each cell
   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } rot_type;

   // one result beat
   typedef struct packed {
      logic        [HDG_W-1:0] heading;
      logic signed [ALT_W-1:0] alt_abs;
      logic signed [ALT_W-1:0] alt_rel;
      logic signed [POS_W-1:0] east;
      logic signed [POS_W-1:0] north;
   } result_type;

   // atan(2^-i) in 2^-32 turn
   function automatic logic signed [Z_W-1:0] atan_turn(input logic [STAGE_W-1:0] idx);
      logic [31:0] val;
      begin
         unique case (idx)
            5'd0:    val = 32'h20000000;
            5'd1:    val = 32'h12E4051E;
            5'd2:    val = 32'h09FB385B;
            5'd3:    val = 32'h051111D4;
            5'd4:    val = 32'h028B0D43;
            5'd5:    val = 32'h0145D7E1;
            5'd6:    val = 32'h00A2F61E;
            5'd7:    val = 32'h00517C55;
            5'd8:    val = 32'h0028BE53;
            5'd9:    val = 32'h00145F2F;
            5'd10:   val = 32'h000A2F98;
            5'd11:   val = 32'h000517CC;
            5'd12:   val = 32'h00028BE6;
            5'd13:   val = 32'h000145F3;
            5'd14:   val = 32'h0000A2FA;
            5'd15:   val = 32'h0000517D;
            5'd16:   val = 32'h000028BE;
            5'd17:   val = 32'h0000145F;
            5'd18:   val = 32'h00000A30;
            5'd19:   val = 32'h00000518;
            5'd20:   val = 32'h0000028C;
            5'd21:   val = 32'h00000146;
            5'd22:   val = 32'h000000A3;
            5'd23:   val = 32'h00000051;
            default: val = 32'h00000000;
         endcase
         atan_turn = Z_W'(val);
      end
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/hrgo_prep.sv */
// input stage: angle folding into the right half plane and altitude sums
`default_nettype none
module hrgo_prep (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire logic [hrgo_pkg::REQ_W-1:0]  in_data,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output hrgo_pkg::pass_type               out_pass,
   output hrgo_pkg::rot_type                out_rot
);
   import hrgo_pkg::*;

   logic                    valid_ff;
   pass_type                pass_ff, pass_in;
   rot_type                 rot_ff, rot_in;
   logic signed [POS_W-1:0] north, east;
   logic signed [ALT_W-1:0] alt_rel, alt_abs;
   logic        [HDG_W-1:0] heading;
   logic signed [OFS_W-1:0] fwd, right, up;
   logic signed [Z_W-1:0]   z_raw;
   logic signed [ALT_W:0]   rel_sum, abs_sum;

   // unpack the beat
   assign north   = in_data[POS_W-1:0];
   assign east    = in_data[2*POS_W-1:POS_W];
   assign alt_rel = in_data[2*POS_W+ALT_W-1:2*POS_W];
   assign alt_abs = in_data[2*POS_W+2*ALT_W-1:2*POS_W+ALT_W];
   assign heading = in_data[2*POS_W+2*ALT_W+HDG_W-1:2*POS_W+2*ALT_W];
   assign fwd     = in_data[2*POS_W+2*ALT_W+HDG_W+OFS_W-1:2*POS_W+2*ALT_W+HDG_W];
   assign right   = in_data[2*POS_W+2*ALT_W+HDG_W+2*OFS_W-1:2*POS_W+2*ALT_W+HDG_W+OFS_W];
   assign up      = in_data[REQ_W-1:2*POS_W+2*ALT_W+HDG_W+2*OFS_W];

   // heading in 2^-32 turn, signed half turn range
   assign z_raw = Z_W'($signed({heading, 16'h0000}));

   assign rel_sum = (ALT_W+1)'(alt_rel) + (ALT_W+1)'(up);
   assign abs_sum = (ALT_W+1)'(alt_abs) + (ALT_W+1)'(up);

   // fold angle and saturate altitudes
   always_comb begin
      pass_in.north   = north;
      pass_in.east    = east;
      pass_in.fwd     = fwd;
      pass_in.right   = right;
      pass_in.heading = heading;
      pass_in.alt_rel = (rel_sum[ALT_W] != rel_sum[ALT_W-1])
                        ? {rel_sum[ALT_W], {(ALT_W-1){~rel_sum[ALT_W]}}}
                        : rel_sum[ALT_W-1:0];
      pass_in.alt_abs = (abs_sum[ALT_W] != abs_sum[ALT_W-1])
                        ? {abs_sum[ALT_W], {(ALT_W-1){~abs_sum[ALT_W]}}}
                        : abs_sum[ALT_W-1:0];
      rot_in.x = CORDIC_X0;
      rot_in.y = '0;
      priority if (z_raw > QUARTER_TURN) begin
         rot_in.z     = z_raw - HALF_TURN;
         pass_in.flip = 1'b1;
      end else if (z_raw < -QUARTER_TURN) begin
         rot_in.z     = z_raw + HALF_TURN;
         pass_in.flip = 1'b1;
      end else begin
         rot_in.z     = z_raw;
         pass_in.flip = 1'b0;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   // stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         pass_ff <= pass_in;
         rot_ff  <= rot_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pass  = pass_ff;
   assign out_rot   = rot_ff;

endmodule
`default_nettype wire

/* hw/rtl/hrgo_cell.sv */
// one cordic rotation cell of the chain
`default_nettype none
module hrgo_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [hrgo_pkg::STAGE_W-1:0]  stage_idx,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire hrgo_pkg::pass_type            in_pass,
   input  wire hrgo_pkg::rot_type             in_rot,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output hrgo_pkg::pass_type                 out_pass,
   output hrgo_pkg::rot_type                  out_rot
);
   import hrgo_pkg::*;

   logic                   valid_ff;
   pass_type               pass_ff;
   rot_type                rot_ff, rot_in;
   logic signed [XY_W-1:0] dx, dy;
   logic signed [Z_W-1:0]  angle;

   // shifted terms, floor shift by the cell's index
   assign dx    = in_rot.y >>> stage_idx;
   assign dy    = in_rot.x >>> stage_idx;
   assign angle = atan_turn(stage_idx);

   // rotate toward zero residual angle
   always_comb begin
      if (!in_rot.z[Z_W-1]) begin
         rot_in.x = in_rot.x - dx;
         rot_in.y = in_rot.y + dy;
         rot_in.z = in_rot.z - angle;
      end else begin
         rot_in.x = in_rot.x + dx;
         rot_in.y = in_rot.y - dy;
         rot_in.z = in_rot.z + angle;
      end
   end

   assign in_ready = !valid_ff || out_ready;

   // cell register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         pass_ff <= in_pass;
         rot_ff  <= rot_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_pass  = pass_ff;
   assign out_rot   = rot_ff;

endmodule
`default_nettype wire

/* hw/rtl/hrgo_post.sv */
// offset products, rounding and saturating position sums
`default_nettype none
module hrgo_post (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire hrgo_pkg::pass_type  in_pass,
   input  wire hrgo_pkg::rot_type   in_rot,
   output logic                     out_valid,
   input  wire logic                out_ready,
   output hrgo_pkg::result_type     out_result
);
   import hrgo_pkg::*;

   // product stage
   logic                     m_valid_ff, m_ready;
   pass_type                 m_pass_ff;
   logic signed [PROD_W-1:0] fc_ff, rs_ff, fs_ff, rc_ff;
   logic signed [PROD_W-1:0] fc_in, rs_in, fs_in, rc_in;
   // rounding stage
   logic                     d_valid_ff, d_ready;
   pass_type                 d_pass_ff;
   logic signed [DIFF_W-1:0] dn_ff, de_ff, dn_in, de_in, dn_raw, de_raw;
   // output stage
   logic                     o_valid_ff, o_ready;
   result_type               result_ff, result_in;
   logic signed [DELTA_W-1:0] dn, de;
   logic signed [POS_W:0]    n_sum, e_sum;

   assign o_ready  = !o_valid_ff || out_ready;
   assign d_ready  = !d_valid_ff || o_ready;
   assign m_ready  = !m_valid_ff || d_ready;
   assign in_ready = m_ready;

   // four products of offsets with cos and sin
   assign fc_in = in_pass.fwd * in_rot.x;
   assign rs_in = in_pass.right * in_rot.y;
   assign fs_in = in_pass.fwd * in_rot.y;
   assign rc_in = in_pass.right * in_rot.x;

   // differences, sign from the half turn fold, plus a half for rounding
   assign dn_raw = DIFF_W'(fc_ff) - DIFF_W'(rs_ff);
   assign de_raw = DIFF_W'(fs_ff) + DIFF_W'(rc_ff);
   assign dn_in  = (m_pass_ff.flip ? -dn_raw : dn_raw) + ROUND_HALF;
   assign de_in  = (m_pass_ff.flip ? -de_raw : de_raw) + ROUND_HALF;

   // drop the fraction and add to the position
   assign dn    = dn_ff[DIFF_W-1:Q_BITS];
   assign de    = de_ff[DIFF_W-1:Q_BITS];
   assign n_sum = (POS_W+1)'(d_pass_ff.north) + (POS_W+1)'(dn);
   assign e_sum = (POS_W+1)'(d_pass_ff.east) + (POS_W+1)'(de);

   // saturate to the field limits
   always_comb begin
      result_in.north   = (n_sum[POS_W] != n_sum[POS_W-1])
                          ? {n_sum[POS_W], {(POS_W-1){~n_sum[POS_W]}}}
                          : n_sum[POS_W-1:0];
      result_in.east    = (e_sum[POS_W] != e_sum[POS_W-1])
                          ? {e_sum[POS_W], {(POS_W-1){~e_sum[POS_W]}}}
                          : e_sum[POS_W-1:0];
      result_in.alt_rel = d_pass_ff.alt_rel;
      result_in.alt_abs = d_pass_ff.alt_abs;
      result_in.heading = d_pass_ff.heading;
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (m_ready) begin
            m_valid_ff <= in_valid;
         end
         if (d_ready) begin
            d_valid_ff <= m_valid_ff;
         end
         if (o_ready) begin
            o_valid_ff <= d_valid_ff;
         end
      end
      if (m_ready && in_valid) begin
         m_pass_ff <= in_pass;
         fc_ff     <= fc_in;
         rs_ff     <= rs_in;
         fs_ff     <= fs_in;
         rc_ff     <= rc_in;
      end
      if (d_ready && m_valid_ff) begin
         d_pass_ff <= m_pass_ff;
         dn_ff     <= dn_in;
         de_ff     <= de_in;
      end
      if (o_ready && d_valid_ff) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = o_valid_ff;
   assign out_result = result_ff;

endmodule
`default_nettype wire

/* hw/rtl/heading_rotated_grid_offset.sv */
// top level: body frame offset rotated by heading and added to a grid position
//
// Moves a grid position by a forward/right/up offset. The horizontal offset is
// rotated by the heading through a chain of CORDIC cells, one cell per rotation
// step (16 by default, never more than 24), then rounded to the millimetre and
// added to northing and easting with saturation; the up offset is added to both
// altitudes with saturation and the heading comes out unchanged. The block takes
// one beat per cycle while the result side is ready and holds up to NUM_CELLS + 4
// beats in flight; a beat passes NUM_CELLS + 4 registers (20 at default) in the
// input stage, the cell chain and three stages of multiply, round and sum. Each
// stage stalls only when it is full and the one after it is stalled, so bubbles
// close up while the result side waits.
`default_nettype none
module heading_rotated_grid_offset (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // northing[39:0] easting[79:40] alt_relative[103:80] alt_absolute[127:104]
   // heading[143:128] forward[167:144] right[191:168] up[215:192]
   input  wire logic [hrgo_pkg::REQ_W-1:0]  req_tdata,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // new_northing[39:0] new_easting[79:40] new_alt_relative[103:80]
   // new_alt_absolute[127:104] heading_out[143:128]
   output logic [hrgo_pkg::RSP_W-1:0]       rsp_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready
);
   import hrgo_pkg::*;

   // links between the stages, index 0 is the input stage output
   logic       link_valid [NUM_CELLS+1];
   logic       link_ready [NUM_CELLS+1];
   pass_type   link_pass  [NUM_CELLS+1];
   rot_type    link_rot   [NUM_CELLS+1];
   result_type result;

   // input stage
   hrgo_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_pass  (link_pass[0]),
      .out_rot   (link_rot[0])
   );

   // rotation cells
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      hrgo_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (STAGE_W'(i)),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_pass   (link_pass[i]),
         .in_rot    (link_rot[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_pass  (link_pass[i+1]),
         .out_rot   (link_rot[i+1])
      );
   end

   // products, rounding and output register
   hrgo_post u_post (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (link_valid[NUM_CELLS]),
      .in_ready   (link_ready[NUM_CELLS]),
      .in_pass    (link_pass[NUM_CELLS]),
      .in_rot     (link_rot[NUM_CELLS]),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (result)
   );

   assign rsp_tdata = result;

endmodule
`default_nettype wire

/* hw/rtl/hrgo_checker.sv */
// port level checks for the heading offset block, bound to the top level
`default_nettype none
module hrgo_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   input  wire logic                        req_tready,
   input  wire logic [hrgo_pkg::RSP_W-1:0]  rsp_tdata,
   input  wire logic                        rsp_tvalid,
   input  wire logic                        rsp_tready
);
   import hrgo_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             req_beat, rsp_beat;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;

   // beats inside the block
   always_comb begin
      count_in = count_ff;
      if (req_beat && !rsp_beat) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rsp_beat && !req_beat) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // no result beat left over after reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a waiting result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // every result comes from an accepted beat
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> count_ff != '0)
      else $error("result beat without an accepted request");

   // never more beats inside than stages
   a_depth: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(PIPE_DEPTH))
      else $error("more beats in flight than pipeline stages");

endmodule

bind heading_rotated_grid_offset hrgo_checker u_hrgo_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
`default_nettype wire

/* bench/heading_rotated_grid_offset_tb.sv */
// self-checking bench for the heading rotated grid offset block: cordic predictor plus scoreboard
`timescale 1ns / 1ps
module heading_rotated_grid_offset_tb;
   import hrgo_pkg::*;

   // one request beat, last declared field (north) in the lowest bits
   typedef struct packed {
      logic signed [OFS_W-1:0] up;
      logic signed [OFS_W-1:0] right;
      logic signed [OFS_W-1:0] forward;
      logic        [HDG_W-1:0] heading;
      logic signed [ALT_W-1:0] alt_abs;
      logic signed [ALT_W-1:0] alt_rel;
      logic signed [POS_W-1:0] east;
      logic signed [POS_W-1:0] north;
   } offset_request_type;

   // flavors of random request
   typedef enum int {MIX_TYPICAL, MIX_FULL, MIX_EDGE, MIX_HEADING} mix_type;

   localparam longint POS_MAX      = (longint'(1) << (POS_W - 1)) - 1;
   localparam longint POS_MIN      = -POS_MAX - 1;
   localparam longint ALT_MAX      = (longint'(1) << (ALT_W - 1)) - 1;
   localparam longint ALT_MIN      = -ALT_MAX - 1;
   localparam longint OFS_MAX      = (longint'(1) << (OFS_W - 1)) - 1;
   localparam longint OFS_MIN      = -OFS_MAX - 1;
   localparam longint INV_GAIN_Q30 = 652032874;
   localparam longint QUARTER      = longint'(1) << 30;
   localparam longint HALF         = longint'(1) << 31;
   localparam int     ROT_STEPS    = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
   localparam int     QUIET_LIMIT  = 2000;
   localparam int     SHOW_LIMIT   = 10;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic             idling     = 1'b1;

   // atan(2^-i) in 2^-32 turn
   longint atan_steps [0:23] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
      64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
      64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
   };

   result_type positions_due[$];
   result_type want_pos;
   result_type got_pos;
   bit         want_clipped;
   int         mismatches      = 0;
   int         beats_sent      = 0;
   int         results_checked = 0;
   int         clipped_results = 0;
   int         quiet_cycles    = 0;

   heading_rotated_grid_offset i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // clamp to a signed field of width w
   function automatic longint clamp(input longint v, input int w);
      longint hi;
      longint lo;
      hi = (longint'(1) << (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // q30 product to millimetres, halves toward plus infinity
   function automatic longint round_mm(input longint v);
      return (v + (longint'(1) << 29)) >>> 30;
   endfunction

   // expected result for one request; clipped tells whether any field saturated
   function automatic result_type offset_position(input offset_request_type b,
                                                  output bit clipped);
      result_type r;
      longint     z, x, y, dx, dy, dn, de, sn, se, sr, sa;
      bit         flip;
      int         i;
      z = longint'($signed({b.heading, 16'h0000}));
      x = INV_GAIN_Q30;
      y = 0;
      flip = 1'b0;
      // fold the back half plane onto the front one
      if (z > QUARTER) begin
         z = z - HALF;
         flip = 1'b1;
      end else if (z < -QUARTER) begin
         z = z + HALF;
         flip = 1'b1;
      end
      for (i = 0; i < ROT_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - atan_steps[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + atan_steps[i];
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      // x is cos, y is sin, both q2.30
      dn = round_mm(longint'(b.forward) * x - longint'(b.right) * y);
      de = round_mm(longint'(b.forward) * y + longint'(b.right) * x);
      sn = longint'(b.north) + dn;
      se = longint'(b.east) + de;
      sr = longint'(b.alt_rel) + longint'(b.up);
      sa = longint'(b.alt_abs) + longint'(b.up);
      clipped = (clamp(sn, POS_W) != sn) || (clamp(se, POS_W) != se) ||
                (clamp(sr, ALT_W) != sr) || (clamp(sa, ALT_W) != sa);
      r.north   = POS_W'(clamp(sn, POS_W));
      r.east    = POS_W'(clamp(se, POS_W));
      r.alt_rel = ALT_W'(clamp(sr, ALT_W));
      r.alt_abs = ALT_W'(clamp(sa, ALT_W));
      r.heading = b.heading;
      return r;
   endfunction

   task automatic note_mismatch(input string what, input logic signed [63:0] want,
                                input logic signed [63:0] got);
      mismatches++;
      if (mismatches <= SHOW_LIMIT)
         $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   // scoreboard: predict on each request beat, check each result beat
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            want_pos = offset_position(offset_request_type'(req_tdata), want_clipped);
            if (want_clipped) clipped_results++;
            positions_due.push_back(want_pos);
         end
         if (rsp_tvalid && rsp_tready) begin
            got_pos = result_type'(rsp_tdata);
            if (positions_due.size() == 0) begin
               mismatches++;
               if (mismatches <= SHOW_LIMIT)
                  $display("%0t result beat with nothing expected: %h", $realtime, rsp_tdata);
            end else begin
               want_pos = positions_due.pop_front();
               results_checked++;
               if (got_pos.north !== want_pos.north)
                  note_mismatch("new_northing", want_pos.north, got_pos.north);
               if (got_pos.east !== want_pos.east)
                  note_mismatch("new_easting", want_pos.east, got_pos.east);
               if (got_pos.alt_rel !== want_pos.alt_rel)
                  note_mismatch("new_alt_relative", want_pos.alt_rel, got_pos.alt_rel);
               if (got_pos.alt_abs !== want_pos.alt_abs)
                  note_mismatch("new_alt_absolute", want_pos.alt_abs, got_pos.alt_abs);
               if (got_pos.heading !== want_pos.heading)
                  note_mismatch("heading_out", want_pos.heading, got_pos.heading);
            end
         end
      end
   end

   // result side back pressure
   always @(posedge clock)
      rsp_tready <= !idling || ($urandom_range(0, 99) >= 12);

   // watchdog on cycles with no beat on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no beat accepted for %0d cycles", quiet_cycles);
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // signed random value of the given width, sign extended
   function automatic longint rand_signed(input int bits);
      longint u;
      u = {$urandom(), $urandom()};
      return (u << (64 - bits)) >>> (64 - bits);
   endfunction

   function automatic longint near_limit(input longint hi, input longint lo, input int span);
      longint d;
      d = longint'($urandom_range(0, span));
      return $urandom_range(0, 1) ? hi - d : lo + d;
   endfunction

   function automatic offset_request_type random_request(input mix_type mix);
      offset_request_type b;
      logic [HDG_W-1:0] specials [0:10];
      specials = '{16'h0000, 16'h3FFF, 16'h4000, 16'h4001, 16'h7FFF, 16'h8000,
                   16'h8001, 16'hBFFF, 16'hC000, 16'hC001, 16'hFFFF};
      b.north   = POS_W'(rand_signed(33));
      b.east    = POS_W'(rand_signed(33));
      b.alt_rel = ALT_W'(rand_signed(18));
      b.alt_abs = ALT_W'(rand_signed(20));
      b.heading = HDG_W'($urandom());
      b.forward = OFS_W'(rand_signed(17));
      b.right   = OFS_W'(rand_signed(17));
      b.up      = OFS_W'(rand_signed(14));
      case (mix)
         MIX_FULL: begin
            b.north   = POS_W'(rand_signed(POS_W));
            b.east    = POS_W'(rand_signed(POS_W));
            b.alt_rel = ALT_W'(rand_signed(ALT_W));
            b.alt_abs = ALT_W'(rand_signed(ALT_W));
            b.forward = OFS_W'(rand_signed(OFS_W));
            b.right   = OFS_W'(rand_signed(OFS_W));
            b.up      = OFS_W'(rand_signed(OFS_W));
         end
         MIX_EDGE: begin
            b.north   = POS_W'(near_limit(POS_MAX, POS_MIN, 1 << 24));
            b.east    = POS_W'(near_limit(POS_MAX, POS_MIN, 1 << 24));
            b.alt_rel = ALT_W'(near_limit(ALT_MAX, ALT_MIN, 1 << 21));
            b.alt_abs = ALT_W'(near_limit(ALT_MAX, ALT_MIN, 1 << 21));
            b.forward = OFS_W'(rand_signed(OFS_W));
            b.right   = OFS_W'(rand_signed(OFS_W));
            b.up      = OFS_W'(rand_signed(OFS_W));
         end
         MIX_HEADING: begin
            b.heading = specials[$urandom_range(0, 10)] + HDG_W'($urandom_range(0, 4)) - 16'd2;
            b.forward = OFS_W'(rand_signed(OFS_W));
            b.right   = OFS_W'(rand_signed(OFS_W));
         end
         default: ;
      endcase
      return b;
   endfunction

   // offer one beat and hold it until taken; valid stays high for a following beat
   task automatic send_beat(input offset_request_type b);
      if (idling && $urandom_range(0, 99) < 12) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tdata  <= b;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic send_fields(input longint n, input longint e, input longint ar,
                              input longint aa, input logic [HDG_W-1:0] h, input longint f,
                              input longint r, input longint u);
      offset_request_type b;
      b.north   = POS_W'(n);
      b.east    = POS_W'(e);
      b.alt_rel = ALT_W'(ar);
      b.alt_abs = ALT_W'(aa);
      b.heading = h;
      b.forward = OFS_W'(f);
      b.right   = OFS_W'(r);
      b.up      = OFS_W'(u);
      send_beat(b);
   endtask

   task automatic wait_drained();
      while (positions_due.size() != 0) @(posedge clock);
   endtask

   // quadrant edges, field extremes, saturation both ways and rounding
   task automatic test_corner_cases();
      send_fields(0, 0, 0, 0, 16'h0000, 0, 0, 0);
      send_fields(1000, -1000, 500, -500, 16'h0000, 1000, 0, 10);
      send_fields(0, 0, 0, 0, 16'h4000, 1000, 1000, 0);
      send_fields(0, 0, 0, 0, 16'h4001, 1000, 1000, 0);
      send_fields(0, 0, 0, 0, 16'h8000, 1000, -1000, 0);
      send_fields(0, 0, 0, 0, 16'hBFFF, 1000, 1000, 0);
      send_fields(0, 0, 0, 0, 16'hC000, 1000, 1000, 0);
      send_fields(0, 0, 0, 0, 16'hFFFF, OFS_MAX, OFS_MAX, 0);
      send_fields(0, 0, ALT_MAX, ALT_MAX, 16'h2000, OFS_MIN, OFS_MIN, OFS_MAX);
      send_fields(0, 0, ALT_MIN, ALT_MIN, 16'h6000, OFS_MAX, OFS_MIN, OFS_MIN);
      send_fields(POS_MAX, POS_MAX, 0, 0, 16'h2000, OFS_MAX, OFS_MAX, 0);
      send_fields(POS_MIN, POS_MIN, 0, 0, 16'hA000, OFS_MAX, OFS_MAX, 0);
      send_fields(POS_MAX, POS_MIN, ALT_MAX, ALT_MIN, 16'h8000, OFS_MAX, OFS_MIN, OFS_MIN);
      send_fields(POS_MIN, POS_MAX, ALT_MIN, ALT_MAX, 16'h0000, OFS_MIN, OFS_MAX, OFS_MAX);
      send_fields(0, 0, 0, 0, 16'h1555, 1, -1, 0);
      send_fields(0, 0, 0, 0, 16'h2000, 3, 0, 0);
      send_fields(-1, -1, -1, -1, 16'h7FFF, -1, -1, -1);
   endtask

   task automatic test_random_traffic(input int count);
      int      k;
      int      pick;
      mix_type mix;
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) mix = MIX_TYPICAL;
         else if (pick < 75) mix = MIX_FULL;
         else if (pick < 90) mix = MIX_EDGE;
         else mix = MIX_HEADING;
         send_beat(random_request(mix));
      end
   endtask

   // back to back beats with both sides always ready
   task automatic test_full_rate(input int count);
      int k;
      idling <= 1'b0;
      for (k = 0; k < count; k++) send_beat(random_request(MIX_FULL));
      idling <= 1'b1;
   endtask

   // let the pipeline run dry, then refill it
   task automatic test_drain_then_burst(input int count);
      int k;
      for (k = 0; k < count; k++) send_beat(random_request(MIX_TYPICAL));
      req_tvalid <= 1'b0;
      wait_drained();
      for (k = 0; k < count; k++) send_beat(random_request(MIX_EDGE));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_cases();
      test_random_traffic(580);
      test_full_rate(60);
      test_drain_then_burst(30);
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (PIPE_DEPTH + 8) @(posedge clock);
      $display("sent %0d position updates, checked %0d results, %0d of them saturated",
               beats_sent, results_checked, clipped_results);
      $display("covered quadrant edges, field extremes, full rate and a drained pipeline");
      if (positions_due.size() != 0)
         $display("%0d expected results never arrived", positions_due.size());
      if (mismatches == 0 && positions_due.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
